// ===== rtl/core/pwmr_pkg.sv =====
// ----------------------------------------------------------------------------
// pwmr_pkg
// Shared types, register map and reset constants for the PWM speed ramp
// with current limiting.
// ----------------------------------------------------------------------------
package pwmr_pkg;

   // field widths
   localparam int DUTY_W   = 8;
   localparam int SAMPLE_W = 8;
   localparam int SPEED_W  = 2;
   localparam int ADDR_W   = 4;
   localparam int DATA_W   = 32;
   localparam int REG_IDX_W = 2;

   // register reset values
   localparam logic [DUTY_W-1:0]   MIN_DUTY_RESET      = 8'd13;
   localparam logic [SAMPLE_W-1:0] TRIM_LIMIT_RESET    = 8'd82;
   localparam logic [SAMPLE_W-1:0] CURRENT_LIMIT_RESET = 8'd35;

   // register indexes (byte address / 4)
   typedef enum logic [REG_IDX_W-1:0] {
      REG_MIN_DUTY      = 2'd0,
      REG_TRIM_LIMIT    = 2'd1,
      REG_CURRENT_LIMIT = 2'd2
   } reg_idx_type;

   // item kinds
   typedef enum logic {
      REQ_RAMP_TICK = 1'b0,
      REQ_CURRENT   = 1'b1
   } req_kind_type;

   // configuration values seen by the datapath
   typedef struct packed {
      logic [DUTY_W-1:0]   min_duty;
      logic [SAMPLE_W-1:0] trim_limit;
      logic [SAMPLE_W-1:0] current_limit;
   } cfg_type;

   // one input item as held in the input register
   typedef struct packed {
      req_kind_type        kind;
      logic [SPEED_W-1:0]  speed_select;
      logic [SAMPLE_W-1:0] trim_sample;
      logic [SAMPLE_W-1:0] current_sample;
   } req_item_type;

endpackage

// ===== rtl/core/pwmr_csr.sv =====
// ----------------------------------------------------------------------------
// pwmr_csr
// Configuration register file behind a simple APB-style port.
// ----------------------------------------------------------------------------
module pwmr_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [pwmr_pkg::ADDR_W-1:0]   paddr,
   input  logic [pwmr_pkg::DATA_W-1:0]   pwdata,
   output logic [pwmr_pkg::DATA_W-1:0]   prdata,
   output logic                          pready,
   output pwmr_pkg::cfg_type             cfg
);

   pwmr_pkg::cfg_type     cfg_ff;
   pwmr_pkg::cfg_type     cfg_in;
   logic                  wr_en;
   pwmr_pkg::reg_idx_type reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = pwmr_pkg::reg_idx_type'(paddr[pwmr_pkg::ADDR_W-1:2]);

   // write decode, unmapped addresses are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            pwmr_pkg::REG_MIN_DUTY:      cfg_in.min_duty      = pwdata[7:0];
            pwmr_pkg::REG_TRIM_LIMIT:    cfg_in.trim_limit    = pwdata[7:0];
            pwmr_pkg::REG_CURRENT_LIMIT: cfg_in.current_limit = pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_duty      <= pwmr_pkg::MIN_DUTY_RESET;
         cfg_ff.trim_limit    <= pwmr_pkg::TRIM_LIMIT_RESET;
         cfg_ff.current_limit <= pwmr_pkg::CURRENT_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      prdata = '0;
      unique case (reg_idx)
         pwmr_pkg::REG_MIN_DUTY:      prdata[7:0] = cfg_ff.min_duty;
         pwmr_pkg::REG_TRIM_LIMIT:    prdata[7:0] = cfg_ff.trim_limit;
         pwmr_pkg::REG_CURRENT_LIMIT: prdata[7:0] = cfg_ff.current_limit;
         default: ;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/pwmr_core.sv =====
// ----------------------------------------------------------------------------
// pwmr_core
// Ramp and current-limit datapath. The state registers double as the
// result register: they only change when the previous result has left.
// ----------------------------------------------------------------------------
module pwmr_core (
   input  logic                           clock,
   input  logic                           reset,
   input  pwmr_pkg::cfg_type              cfg,
   input  logic                           in_valid,
   input  pwmr_pkg::req_item_type         in_item,
   output logic                           in_take,
   output logic                           out_valid,
   input  logic                           out_stall,
   output logic [pwmr_pkg::DUTY_W-1:0]    out_compare,
   output logic                           out_accel,
   output logic                           out_stable,
   output logic                           out_chuff,
   output logic                           out_alarm
);

   logic [pwmr_pkg::DUTY_W-1:0] duty_ff, duty_in;
   logic [pwmr_pkg::DUTY_W-1:0] compare_ff, compare_in;
   logic over_current_ff, over_current_in;
   logic accel_ff, accel_in;
   logic stable_ff, stable_in;
   logic chuff_ff, chuff_in;
   logic alarm_ff, alarm_in;
   logic out_valid_ff, out_valid_in;

   logic [pwmr_pkg::SAMPLE_W-2:0] trim_half;
   logic [pwmr_pkg::SAMPLE_W-1:0] trim_clamped;
   logic [pwmr_pkg::SAMPLE_W+1:0] target_wide;
   logic [pwmr_pkg::DUTY_W-1:0]   target;
   logic [pwmr_pkg::DUTY_W-1:0]   duty_next;

   // item moves on when the result slot is free or being emptied
   assign in_take = in_valid && (!out_valid_ff || !out_stall);

   // target duty: halve, clamp, scale by speed, saturate
   always_comb begin
      trim_half = in_item.trim_sample[pwmr_pkg::SAMPLE_W-1:1];
      if ({1'b0, trim_half} > cfg.trim_limit) begin
         trim_clamped = cfg.trim_limit;
      end else begin
         trim_clamped = {1'b0, trim_half};
      end
      target_wide = {2'b00, trim_clamped}
                    * {{pwmr_pkg::SAMPLE_W{1'b0}}, in_item.speed_select};
      if (target_wide > {2'b00, {pwmr_pkg::DUTY_W{1'b1}}}) begin
         target = {pwmr_pkg::DUTY_W{1'b1}};
      end else begin
         target = target_wide[pwmr_pkg::DUTY_W-1:0];
      end
   end

   // state update for one item
   always_comb begin
      duty_in         = duty_ff;
      compare_in      = compare_ff;
      over_current_in = over_current_ff;
      accel_in        = accel_ff;
      stable_in       = stable_ff;
      chuff_in        = chuff_ff;
      alarm_in        = alarm_ff;
      duty_next       = duty_ff;
      if (in_take) begin
         case (in_item.kind)
            pwmr_pkg::REQ_RAMP_TICK: begin
               if (duty_ff > target) begin
                  if (duty_ff < cfg.min_duty) begin
                     duty_next = '0;
                  end else begin
                     duty_next = duty_ff - 1'b1;
                  end
                  accel_in  = 1'b0;
                  stable_in = 1'b0;
               end else if (duty_ff < target) begin
                  if (duty_ff == '0) begin
                     duty_next = cfg.min_duty;
                     chuff_in  = 1'b1;
                  end else begin
                     duty_next = duty_ff + 1'b1;
                  end
                  accel_in  = 1'b1;
                  stable_in = 1'b0;
               end else begin
                  stable_in = 1'b1;
                  accel_in  = 1'b0;
                  chuff_in  = 1'b0;
               end
               duty_in = duty_next;
               if (!over_current_ff) begin
                  alarm_in   = 1'b0;
                  compare_in = duty_next;
               end
            end
            pwmr_pkg::REQ_CURRENT: begin
               if (in_item.current_sample > cfg.current_limit) begin
                  alarm_in        = 1'b1;
                  over_current_in = 1'b1;
                  compare_in      = cfg.min_duty;
               end else begin
                  over_current_in = 1'b0;
                  compare_in      = duty_ff;
               end
            end
            default: ;
         endcase
      end
   end

   // result valid
   always_comb begin
      out_valid_in = out_valid_ff;
      if (in_take) begin
         out_valid_in = 1'b1;
      end else if (!out_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_ff         <= '0;
         compare_ff      <= '0;
         over_current_ff <= 1'b0;
         accel_ff        <= 1'b0;
         stable_ff       <= 1'b0;
         chuff_ff        <= 1'b0;
         alarm_ff        <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         duty_ff         <= duty_in;
         compare_ff      <= compare_in;
         over_current_ff <= over_current_in;
         accel_ff        <= accel_in;
         stable_ff       <= stable_in;
         chuff_ff        <= chuff_in;
         alarm_ff        <= alarm_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   assign out_valid   = out_valid_ff;
   assign out_compare = compare_ff;
   assign out_accel   = accel_ff;
   assign out_stable  = stable_ff;
   assign out_chuff   = chuff_ff;
   assign out_alarm   = alarm_ff;

endmodule

// ===== rtl/core/pwm_speed_ramp_current_limit.sv =====
// ----------------------------------------------------------------------------
// pwm_speed_ramp_current_limit
// PWM soft-start speed ramp with over-current limiting.
// ----------------------------------------------------------------------------
// Each transfer on the req_ channel is either a ramp tick (speed select and
// trim sample) or a current sample, and yields exactly one transfer on the
// rsp_ channel showing the compare value and flags after that item. The
// block takes one item per clock while rsp_ is not stalled; a result
// passes through the input register, then the state/result register, and
// a stall on rsp_ holds the input register, which in turn stalls req_.
// Registers min_duty (0x0), trim_limit (0x4) and current_limit (0x8) are
// written through the APB-style port and should only change while idle.
module pwm_speed_ramp_current_limit (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_type,
   input  logic [pwmr_pkg::SPEED_W-1:0]   req_speed_select,
   input  logic [pwmr_pkg::SAMPLE_W-1:0]  req_trim_sample,
   input  logic [pwmr_pkg::SAMPLE_W-1:0]  req_current_sample,
   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [pwmr_pkg::DUTY_W-1:0]    rsp_pwm_compare,
   output logic                           rsp_accelerating,
   output logic                           rsp_at_speed,
   output logic                           rsp_chuff,
   output logic                           rsp_alarm,
   // configuration port
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [pwmr_pkg::ADDR_W-1:0]    paddr,
   input  logic [pwmr_pkg::DATA_W-1:0]    pwdata,
   output logic [pwmr_pkg::DATA_W-1:0]    prdata,
   output logic                           pready
);

   pwmr_pkg::cfg_type      cfg;
   pwmr_pkg::req_item_type in_item_ff, in_item_in;
   logic                   in_valid_ff, in_valid_in;
   logic                   in_take;

   // configuration registers
   pwmr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // input register, held while the datapath cannot take it
   assign req_stall = in_valid_ff && !in_take;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         if (req_valid) begin
            in_item_in.kind           = pwmr_pkg::req_kind_type'(req_type);
            in_item_in.speed_select   = req_speed_select;
            in_item_in.trim_sample    = req_trim_sample;
            in_item_in.current_sample = req_current_sample;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
   end

   // ramp and current-limit datapath with result register
   pwmr_core u_core (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .in_valid    (in_valid_ff),
      .in_item     (in_item_ff),
      .in_take     (in_take),
      .out_valid   (rsp_valid),
      .out_stall   (rsp_stall),
      .out_compare (rsp_pwm_compare),
      .out_accel   (rsp_accelerating),
      .out_stable  (rsp_at_speed),
      .out_chuff   (rsp_chuff),
      .out_alarm   (rsp_alarm)
   );

endmodule
